// File: rtl/ssid_pkg.sv
`timescale 1ns / 1ps
package ssid_pkg;

    localparam int CAP_DEF         = 64;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int VAL_W           = 32;
    localparam int CNT_W           = 7;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_STREAM
    } t_state;

    typedef enum logic [1:0] {
        M_KEEP,
        M_INS,
        M_DEL
    } t_mode;

endpackage

// File: rtl/ssid_if.sv
`timescale 1ns / 1ps
interface ssid_cmd_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic signed [ssid_pkg::VAL_W-1:0] value;

    modport source(output valid, output command, output value, input ready);
    modport sink(input valid, input command, input value, output ready);
endinterface

interface ssid_res_if;
    logic                              valid;
    logic                              ready;
    logic        [ssid_pkg::CNT_W-1:0] count;
    logic signed [ssid_pkg::VAL_W-1:0] element;
    logic                              element_valid;
    logic                              last_of_run;
    logic                              insert_dropped;

    modport source(output valid, output count, output element, output element_valid,
                   output last_of_run, output insert_dropped, input ready);
    modport sink(input valid, input count, input element, input element_valid,
                 input last_of_run, input insert_dropped, output ready);
endinterface

// File: rtl/ssid_ram.sv
`timescale 1ns / 1ps
module ssid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/ssid_front.sv
`timescale 1ns / 1ps
module ssid_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ssid_cmd_if.sink         i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output ssid_pkg::t_entry o_entry
);
    import ssid_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    logic   accept;

    assign i_cmd.ready = !r_valid || i_ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_entry.op    <= t_op'(i_cmd.command);
            r_entry.value <= i_cmd.value;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
endmodule

// File: rtl/ssid_queue.sv
`timescale 1ns / 1ps
module ssid_queue #(
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  ssid_pkg::t_entry i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output ssid_pkg::t_entry o_pop_data
);
    import ssid_pkg::*;

    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != FULL);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end
endmodule

// File: rtl/ssid_back.sv
`timescale 1ns / 1ps
module ssid_back #(
    parameter int CAPACITY = ssid_pkg::CAP_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ssid_pkg::t_entry i_entry,
    ssid_res_if.source       o_res
);
    import ssid_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

    t_state                  r_state, n_state;
    logic                    r_bank, n_bank;
    logic [CNT_W-1:0]        r_count, n_count;
    t_op                     r_op, n_op;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hi, n_hi;
    logic [CNT_W-1:0]        r_mid, n_mid;
    logic                    r_found, n_found;
    t_mode                   r_mode, n_mode;
    logic [CNT_W-1:0]        r_new_cnt, n_new_cnt;
    logic                    r_dropped, n_dropped;
    logic [CNT_W-1:0]        r_iss, n_iss;
    logic                    r_d_valid, n_d_valid;
    logic [CNT_W-1:0]        r_d_idx, n_d_idx;
    logic                    r_d_is_v, n_d_is_v;
    logic                    r_out_valid, n_out_valid;
    logic [CNT_W-1:0]        r_out_count, n_out_count;
    logic signed [VAL_W-1:0] r_out_elem, n_out_elem;
    logic                    r_out_ev, n_out_ev;
    logic                    r_out_last, n_out_last;
    logic                    r_out_drop, n_out_drop;

    logic [CNT_W:0]          mid_sum;
    logic [CNT_W-1:0]        mid;
    logic [CNT_W-1:0]        total;
    logic [CNT_W-1:0]        src;
    logic                    src_is_v;
    logic                    out_free;
    logic                    adv;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic [VAL_W-1:0]        rdata0, rdata1;
    logic signed [VAL_W-1:0] rd_data;
    logic signed [VAL_W-1:0] elem;

    // Two banks: the current table is read from one while the updated table
    // is written into the other during the output pass.
    ssid_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_bank0 (
        .i_clk  (i_clk),
        .i_we   (wr_en && r_bank),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rdata0)
    );

    ssid_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_bank1 (
        .i_clk  (i_clk),
        .i_we   (wr_en && !r_bank),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rdata1)
    );

    assign rd_data  = $signed(r_bank ? rdata1 : rdata0);
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CNT_W:1];
    assign total    = (r_new_cnt == '0) ? ONE : r_new_cnt;
    assign out_free = !r_out_valid || o_res.ready;
    assign adv      = !r_d_valid || out_free;
    assign o_ready  = (r_state == S_IDLE);
    assign elem     = r_d_is_v ? r_value : ((r_new_cnt == '0) ? '0 : rd_data);

    // Source index in the old table for output position r_iss.
    always_comb begin
        src      = r_iss;
        src_is_v = 1'b0;
        unique case (r_mode)
            M_INS: begin
                if (r_iss == r_lo) begin
                    src_is_v = 1'b1;
                end else if (r_iss > r_lo) begin
                    src = r_iss - ONE;
                end
            end
            M_DEL: begin
                if (r_iss >= r_lo) begin
                    src = r_iss + ONE;
                end
            end
            M_KEEP: begin
                src = r_iss;
            end
            default: begin
                src = r_iss;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_count     = r_count;
        n_op        = r_op;
        n_value     = r_value;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_found     = r_found;
        n_mode      = r_mode;
        n_new_cnt   = r_new_cnt;
        n_dropped   = r_dropped;
        n_iss       = r_iss;
        n_d_valid   = r_d_valid;
        n_d_idx     = r_d_idx;
        n_d_is_v    = r_d_is_v;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_count = r_out_count;
        n_out_elem  = r_out_elem;
        n_out_ev    = r_out_ev;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_d_idx[AW-1:0];
        wr_data     = elem;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_entry.op;
                    n_value = i_entry.value;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_found = 1'b0;
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = mid[AW-1:0];
                    n_mid   = mid;
                    n_state = S_SRCH_CMP;
                end else begin
                    // Search done: r_lo is the lower bound position.
                    n_mode    = M_KEEP;
                    n_new_cnt = r_count;
                    n_dropped = 1'b0;
                    if (r_op == OP_INSERT) begin
                        if (!r_found) begin
                            if (r_count >= CAP_N) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_mode    = M_INS;
                                n_new_cnt = r_count + ONE;
                            end
                        end
                    end else if (r_found) begin
                        n_mode    = M_DEL;
                        n_new_cnt = r_count - ONE;
                    end
                    n_iss     = '0;
                    n_d_valid = 1'b0;
                    n_state   = S_STREAM;
                end
            end
            S_SRCH_CMP: begin
                if (rd_data < r_value) begin
                    n_lo = r_mid + ONE;
                end else begin
                    n_hi    = r_mid;
                    n_found = (rd_data == r_value);
                end
                n_state = S_SRCH_RD;
            end
            S_STREAM: begin
                if (adv) begin
                    if (r_d_valid) begin
                        n_out_valid = 1'b1;
                        n_out_count = r_new_cnt;
                        n_out_elem  = elem;
                        n_out_ev    = (r_new_cnt != '0);
                        n_out_last  = ((r_d_idx + ONE) == total);
                        n_out_drop  = r_dropped;
                        wr_en       = (r_new_cnt != '0);
                    end
                    if (r_iss < total) begin
                        rd_en     = (r_new_cnt != '0);
                        rd_addr   = src[AW-1:0];
                        n_d_valid = 1'b1;
                        n_d_idx   = r_iss;
                        n_d_is_v  = src_is_v;
                        n_iss     = r_iss + ONE;
                    end else begin
                        n_d_valid = 1'b0;
                        n_bank    = !r_bank;
                        n_count   = r_new_cnt;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bank      <= n_bank;
            r_count     <= n_count;
            r_d_valid   <= n_d_valid;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_value     <= n_value;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_found     <= n_found;
        r_mode      <= n_mode;
        r_new_cnt   <= n_new_cnt;
        r_dropped   <= n_dropped;
        r_iss       <= n_iss;
        r_d_idx     <= n_d_idx;
        r_d_is_v    <= n_d_is_v;
        r_out_count <= n_out_count;
        r_out_elem  <= n_out_elem;
        r_out_ev    <= n_out_ev;
        r_out_last  <= n_out_last;
        r_out_drop  <= n_out_drop;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.count          = r_out_count;
    assign o_res.element        = r_out_elem;
    assign o_res.element_valid  = r_out_ev;
    assign o_res.last_of_run    = r_out_last;
    assign o_res.insert_dropped = r_out_drop;
endmodule

// File: rtl/sorted_set_insert_delete_core.sv
`timescale 1ns / 1ps
// Sorted set of distinct signed 32-bit values. Each command transaction on i_cmd
// inserts (command 0) or deletes (command 1) one value; afterwards o_res carries
// one transaction per stored value in ascending order, each with the new count,
// the last one flagged by last_of_run, or a single transaction with
// element_valid low when the set is empty. insert_dropped is set on every result
// of an insert of a new value into a full table. A command runs a binary search
// through the registered read port of the table RAM, then one output pass at one
// result per cycle, unless o_res stalls, that also writes the updated table into
// the second RAM bank. A queue of QUEUE_DEPTH entries (two by default) lets a
// following command be taken while results are still being delivered.
module sorted_set_insert_delete_core #(
    parameter int CAPACITY    = ssid_pkg::CAP_DEF,
    parameter int QUEUE_DEPTH = ssid_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssid_cmd_if.sink   i_cmd,
    ssid_res_if.source o_res
);
    import ssid_pkg::*;

    logic   f_valid;
    logic   f_ready;
    t_entry f_entry;
    logic   q_valid;
    logic   q_ready;
    t_entry q_entry;

    ssid_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (i_cmd),
        .o_valid(f_valid),
        .i_ready(f_ready),
        .o_entry(f_entry)
    );

    ssid_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(f_valid),
        .o_push_ready(f_ready),
        .i_push_data (f_entry),
        .o_pop_valid (q_valid),
        .i_pop_ready (q_ready),
        .o_pop_data  (q_entry)
    );

    ssid_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_ready(q_ready),
        .i_entry(q_entry),
        .o_res  (o_res)
    );
endmodule

// File: rtl/ssid_checker.sv
`timescale 1ns / 1ps
module ssid_checker #(
    parameter int CAPACITY = ssid_pkg::CAP_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              i_ready,
    input logic        [ssid_pkg::CNT_W-1:0] i_count,
    input logic signed [ssid_pkg::VAL_W-1:0] i_element,
    input logic                              i_element_valid,
    input logic                              i_last_of_run,
    input logic                              i_insert_dropped
);
    import ssid_pkg::*;

    localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAPACITY);

    // A stalled result keeps its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_count) && $stable(i_element)
            && $stable(i_element_valid) && $stable(i_last_of_run)
            && $stable(i_insert_dropped))
        else $error("result payload changed while stalled");

    // The empty-set marker is the only result of its run and reports no values.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_element_valid |-> i_count == '0 && i_last_of_run)
        else $error("empty-set result with nonzero count or not last");

    // A dropped insert leaves the table full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_insert_dropped |-> i_count == CAP_N && i_element_valid)
        else $error("dropped insert while the table is not full");

    // A result that is not last needs at least one more stored value behind it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last_of_run |-> i_count > CNT_W'(1) && i_count <= CAP_N
            && i_element_valid)
        else $error("non-final result with an impossible count");
endmodule

bind sorted_set_insert_delete_core ssid_checker #(.CAPACITY(CAPACITY)) u_ssid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_count         (o_res.count),
    .i_element       (o_res.element),
    .i_element_valid (o_res.element_valid),
    .i_last_of_run   (o_res.last_of_run),
    .i_insert_dropped(o_res.insert_dropped)
);
